### hdl/rgbc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the 5x5 RGB convolution filter.
// No dependencies.
package rgbc_pkg;

  localparam int KS         = 5;
  localparam int SLOT       = 12;
  localparam int KROW_W     = 60;
  localparam int DIV_W      = 12;
  localparam int OFF_W      = 13;
  localparam int LW_W       = 12;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 24;
  localparam int ACC_W      = 26;
  localparam int MAG_W      = ACC_W - 1;
  localparam int ADDR_W     = 3;
  localparam int TAP_W      = 3;
  localparam int NCH        = 3;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int COEF_BITS_DEF = 12;

  localparam logic [KROW_W-1:0] KROW2_RST = KROW_W'(4096);
  localparam logic [LW_W-1:0]   LW_RST    = LW_W'(640);

  typedef enum logic [ADDR_W-1:0] {
    REG_KROW0   = 3'd0,
    REG_KROW1   = 3'd1,
    REG_KROW2   = 3'd2,
    REG_KROW3   = 3'd3,
    REG_KROW4   = 3'd4,
    REG_DIVISOR = 3'd5,
    REG_OFFSET  = 3'd6,
    REG_LWIDTH  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic             accept;
    logic             commit;
    logic             mac_en;
    logic [TAP_W-1:0] tap_row;
    logic [TAP_W-1:0] tap_col;
    logic             div_start;
    logic             out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
    logic out_busy;
  } dp_sts_t;

endpackage

### hdl/rgb_convolution_5x5.sv
`timescale 1ns / 1ps
// 5x5 convolution filter on an RGB pixel stream with four line buffers.
// out_tvalid rises after an interior pixel is accepted, following line buffer read,
// 25 multiply-accumulate steps, divider start, 25 divider steps, wait, output load.
// The next pixel is accepted only when the previous one is finished; out_tready stalls delay it.
// Reset (rst_n low, synchronous) restores the registers and clears counters and window.
// Depends on rgbc_pkg, rgbc_ctrl and rgbc_dp.
module rgb_convolution_5x5 #(
  parameter int MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEF,
  parameter int COEF_BITS = rgbc_pkg::COEF_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rgbc_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [rgbc_pkg::KROW_W-1:0] cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // red_in[7:0], green_in[15:8], blue_in[23:16].
  input  logic [23:0]                 in_tdata,
  // frame_start.
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16].
  output logic [23:0]                 out_tdata,
  // row_end.
  output logic                        out_tlast
);
  import rgbc_pkg::*;

  ctl_cmd_t         cmd;
  dp_sts_t          sts;
  logic [PIX_W-1:0] in_pix, out_pix;

  assign in_pix    = {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
  assign out_tdata = {out_pix[7:0], out_pix[15:8], out_pix[23:16]};

  rgbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rgbc_dp #(.MAX_WIDTH(MAX_WIDTH), .COEF_BITS(COEF_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_pix    (in_pix),
    .in_fs     (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_pix),
    .out_last  (out_tlast)
  );

endmodule

### hdl/rgbc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rgbc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/rgbc_div.sv
`timescale 1ns / 1ps
// Three-lane restoring divider, one quotient bit per lane and cycle.
// Depends on rgbc_pkg.
module rgbc_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [rgbc_pkg::MAG_W-1:0] num [rgbc_pkg::NCH],
  input  logic [rgbc_pkg::DIV_W-1:0] den,
  output logic                     done,
  output logic [rgbc_pkg::MAG_W-1:0] quot [rgbc_pkg::NCH]
);
  import rgbc_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [MAG_W-1:0] q_r [NCH];
  logic [DIV_W-1:0] rem_r [NCH];
  logic [DIV_W-1:0] d_eff;

  assign d_eff = (den == '0) ? DIV_W'(1) : den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MAG_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  for (genvar i = 0; i < NCH; i++) begin : g_lane
    logic [DIV_W:0] trial;
    logic           ge;
    assign trial = {rem_r[i], q_r[i][MAG_W-1]};
    assign ge    = trial >= {1'b0, d_eff};
    always_ff @(posedge clk) begin
      if (start) begin
        q_r[i]   <= num[i];
        rem_r[i] <= '0;
      end else if (busy_r) begin
        rem_r[i] <= ge ? DIV_W'(trial - {1'b0, d_eff}) : DIV_W'(trial);
        q_r[i]   <= {q_r[i][MAG_W-2:0], ge};
      end
    end
    assign quot[i] = q_r[i];
  end

  assign done = done_r;

endmodule

### hdl/rgbc_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine: accept, line read and, for interior pixels, 25 tap steps, divide, output.
// Depends on rgbc_pkg.
module rgbc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rgbc_pkg::dp_sts_t   sts,
  output rgbc_pkg::ctl_cmd_t  cmd
);
  import rgbc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_MAC, S_DIVGO, S_DIV, S_OUT
  } state_t;

  state_t           state_r;
  logic [TAP_W-1:0] row_r, col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_READ;
        end
        S_READ: begin
          row_r   <= '0;
          col_r   <= '0;
          state_r <= sts.emit ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          if (col_r == TAP_W'(KS - 1)) begin
            col_r <= '0;
            if (row_r == TAP_W'(KS - 1)) begin
              state_r <= S_DIVGO;
            end else begin
              row_r <= row_r + TAP_W'(1);
            end
          end else begin
            col_r <= col_r + TAP_W'(1);
          end
        end
        S_DIVGO: state_r <= S_DIV;
        S_DIV: begin
          if (sts.div_done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (!sts.out_busy) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign cmd.accept    = in_ready && in_valid;
  assign cmd.commit    = (state_r == S_READ);
  assign cmd.mac_en    = (state_r == S_MAC);
  assign cmd.tap_row   = row_r;
  assign cmd.tap_col   = col_r;
  assign cmd.div_start = (state_r == S_DIVGO);
  assign cmd.out_load  = (state_r == S_OUT) && !sts.out_busy;

endmodule

### hdl/rgbc_dp.sv
`timescale 1ns / 1ps
// Datapath: registers, line buffers, window, multiply-accumulate, divide, clamp.
// Depends on rgbc_pkg, rgbc_ram and rgbc_div.
module rgbc_dp #(
  parameter int MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEF,
  parameter int COEF_BITS = rgbc_pkg::COEF_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rgbc_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [rgbc_pkg::KROW_W-1:0] cfg_wdata,
  input  logic [rgbc_pkg::PIX_W-1:0]  in_pix,
  input  logic                        in_fs,
  input  rgbc_pkg::ctl_cmd_t          cmd,
  output rgbc_pkg::dp_sts_t           sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rgbc_pkg::PIX_W-1:0]  out_pix,
  output logic                        out_last
);
  import rgbc_pkg::*;

  localparam int CNT_W = $clog2(MAX_WIDTH);
  localparam int W_W   = (CNT_W + 1 > LW_W) ? CNT_W + 1 : LW_W;
  localparam int PRD_W = COEF_BITS + CH_W + 1;

  logic [KROW_W-1:0] krow_r [KS];
  logic [DIV_W-1:0]  div_r;
  logic [OFF_W-1:0]  off_r;
  logic [LW_W-1:0]   lw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      krow_r[0] <= '0;
      krow_r[1] <= '0;
      krow_r[2] <= KROW2_RST;
      krow_r[3] <= '0;
      krow_r[4] <= '0;
      div_r     <= DIV_W'(1);
      off_r     <= '0;
      lw_r      <= LW_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KROW0, REG_KROW1, REG_KROW2, REG_KROW3, REG_KROW4:
          krow_r[cfg_addr] <= cfg_wdata;
        REG_DIVISOR: div_r <= cfg_wdata[DIV_W-1:0];
        REG_OFFSET:  off_r <= cfg_wdata[OFF_W-1:0];
        REG_LWIDTH:  lw_r  <= cfg_wdata[LW_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] ccnt_r;
  logic [2:0]       rcnt_r;
  logic [CNT_W-1:0] col_r;
  logic [PIX_W-1:0] pix_r;
  logic             emit_r, last_r;
  logic [W_W-1:0]   lw_ext, w_eff, cc_ext;
  logic [CNT_W-1:0] cc;
  logic [2:0]       rc;
  logic             last_c;

  always_comb begin
    lw_ext = W_W'(lw_r);
    if (lw_ext < W_W'(KS)) w_eff = W_W'(KS);
    else if (lw_ext > W_W'(MAX_WIDTH)) w_eff = W_W'(MAX_WIDTH);
    else w_eff = lw_ext;
    cc = in_fs ? '0 : ccnt_r;
    rc = in_fs ? '0 : rcnt_r;
    if (W_W'(cc) >= w_eff) cc = '0;
    cc_ext = W_W'(cc);
    last_c = (cc_ext == w_eff - W_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccnt_r <= '0;
      rcnt_r <= '0;
      emit_r <= 1'b0;
    end else if (cmd.accept) begin
      emit_r <= (rc >= 3'd4) && (cc_ext >= W_W'(4));
      if (last_c) begin
        ccnt_r <= '0;
        if (rc < 3'd4) rcnt_r <= rc + 3'd1;
        else rcnt_r <= rc;
      end else begin
        ccnt_r <= cc + CNT_W'(1);
        rcnt_r <= rc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      col_r  <= cc;
      pix_r  <= in_pix;
      last_r <= last_c;
    end
  end

  logic [PIX_W-1:0] column [KS];

  for (genvar k = 0; k < KS - 1; k++) begin : g_line
    rgbc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
      .clk   (clk),
      .we    (cmd.commit),
      .waddr (col_r),
      .wdata (column[k+1]),
      .raddr (cc),
      .rdata (column[k])
    );
  end
  assign column[KS-1] = pix_r;

  logic [PIX_W-1:0] win_r [KS][KS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < KS; r++) begin
        for (int c = 0; c < KS; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (cmd.commit) begin
      for (int r = 0; r < KS; r++) begin
        for (int c = 0; c < KS - 1; c++) begin
          win_r[r][c] <= win_r[r][c+1];
        end
        win_r[r][KS-1] <= column[r];
      end
    end
  end

  logic [PIX_W-1:0]            tap_pix;
  logic signed [COEF_BITS-1:0] coef;
  logic signed [ACC_W-1:0]     acc_r [NCH];

  assign tap_pix = win_r[cmd.tap_row][cmd.tap_col];
  assign coef    = krow_r[cmd.tap_row][SLOT*cmd.tap_col +: COEF_BITS];

  for (genvar i = 0; i < NCH; i++) begin : g_mac
    logic signed [CH_W:0]    pxs;
    logic signed [PRD_W-1:0] prod;
    assign pxs  = $signed({1'b0, tap_pix[(NCH-1-i)*CH_W +: CH_W]});
    assign prod = coef * pxs;
    always_ff @(posedge clk) begin
      if (cmd.commit) begin
        acc_r[i] <= '0;
      end else if (cmd.mac_en) begin
        acc_r[i] <= acc_r[i] + {{(ACC_W-PRD_W){prod[PRD_W-1]}}, prod};
      end
    end
  end

  logic [MAG_W-1:0] mag [NCH];
  logic [MAG_W-1:0] quot [NCH];
  logic             neg_r [NCH];
  logic             div_done;

  for (genvar i = 0; i < NCH; i++) begin : g_mag
    logic [ACC_W-1:0] absv;
    assign absv   = acc_r[i][ACC_W-1] ? ACC_W'(-acc_r[i]) : ACC_W'(acc_r[i]);
    assign mag[i] = absv[MAG_W-1:0];
    always_ff @(posedge clk) begin
      if (cmd.div_start) neg_r[i] <= acc_r[i][ACC_W-1];
    end
  end

  rgbc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (mag),
    .den   (div_r),
    .done  (div_done),
    .quot  (quot)
  );

  logic [PIX_W-1:0] res_pix;

  for (genvar i = 0; i < NCH; i++) begin : g_clamp
    logic signed [ACC_W-1:0] qs;
    logic signed [ACC_W:0]   res;
    assign qs  = neg_r[i] ? -$signed({1'b0, quot[i]}) : $signed({1'b0, quot[i]});
    assign res = {qs[ACC_W-1], qs} - {{(ACC_W+1-OFF_W){off_r[OFF_W-1]}}, off_r};
    always_comb begin
      if (res[ACC_W]) res_pix[(NCH-1-i)*CH_W +: CH_W] = '0;
      else if (res > (ACC_W+1)'(255)) res_pix[(NCH-1-i)*CH_W +: CH_W] = '1;
      else res_pix[(NCH-1-i)*CH_W +: CH_W] = res[CH_W-1:0];
    end
  end

  logic             ovalid_r, olast_r;
  logic [PIX_W-1:0] opix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      opix_r  <= res_pix;
      olast_r <= last_r;
    end
  end

  assign out_valid    = ovalid_r;
  assign out_pix      = opix_r;
  assign out_last     = olast_r;
  assign sts.emit     = emit_r;
  assign sts.div_done = div_done;
  assign sts.out_busy = ovalid_r && !out_ready;

endmodule
